@@ hdl/q2s_pkg.sv @@
package q2s_pkg;

  localparam logic [1:0] RmNearest = 2'd0;
  localparam logic [1:0] RmZero    = 2'd1;
  localparam logic [1:0] RmUp      = 2'd2;
  localparam logic [1:0] RmDown    = 2'd3;

  localparam logic [0:0] CfgRounding = 1'b0;
  localparam logic [0:0] CfgTrap     = 1'b1;

  localparam logic [4:0] ExcNx = 5'h01;
  localparam logic [4:0] ExcUf = 5'h04;
  localparam logic [4:0] ExcOf = 5'h08;
  localparam logic [4:0] ExcNv = 5'h10;

  localparam logic [30:0] XmHuge  = 31'h407f0000;
  localparam logic [30:0] XmSpec  = 31'h7fff0000;
  localparam logic [30:0] XmNorm  = 31'h3f810000;
  localparam logic [30:0] XmTiny  = 31'h3f690000;
  localparam logic [30:0] XmBias  = 31'h3f800000;
  localparam logic [15:0] ExpBias = 16'h3f80;
  localparam logic [31:0] QNan    = 32'h7fc00000;
  localparam logic [31:0] Inf     = 32'h7f800000;
  localparam logic [31:0] MaxFin  = 32'h7f7fffff;

  typedef enum logic [1:0] {
    KindSpecial = 2'd0,
    KindNormal  = 2'd1,
    KindSub     = 2'd2
  } kind_e;

  // Item after classification and alignment.
  typedef struct packed {
    kind_e       kind;
    logic        sign;
    logic [1:0]  rm;
    logic [4:0]  te;
    logic [31:0] bits;
    logic [4:0]  exc;
    logic        wr;
    logic        rnd;
    logic        sticky;
  } q2s_mid_t;

  typedef struct packed {
    logic [31:0] bits;
    logic [4:0]  exc;
    logic        wr;
    logic        trap;
  } q2s_res_t;

endpackage

@@ hdl/q2s_classify.sv @@
module q2s_classify (
  input  logic [63:0]          quad_high_i,
  input  logic [63:0]          quad_low_i,
  input  logic [1:0]           rm_i,
  input  logic [4:0]           te_i,
  output q2s_pkg::q2s_mid_t    mid_o
);

  logic        sign;
  logic [30:0] xm;
  logic [22:0] frac23;
  logic [1:0]  rm;
  logic        low_nz;
  logic [4:0]  e;
  logic [23:0] mant;
  logic [47:0] wide;
  logic        trp;

  always_comb begin
    sign   = quad_high_i[63];
    xm     = quad_high_i[62:32];
    frac23 = quad_high_i[47:25];
    rm     = sign ? (rm_i ^ {1'b0, rm_i[1]}) : rm_i;
    low_nz = (quad_low_i != 64'd0);
    e      = 5'(q2s_pkg::ExpBias - {1'b0, xm[30:16]});
    mant   = {1'b1, frac23};
    wide   = {mant, 24'd0} >> e;
    mid_o        = '0;
    mid_o.sign   = sign;
    mid_o.rm     = rm;
    mid_o.te     = te_i;
    mid_o.kind   = q2s_pkg::KindSpecial;
    trp          = 1'b0;
    if (xm >= q2s_pkg::XmHuge) begin
      if (xm >= q2s_pkg::XmSpec) begin
        if (xm[15:0] != 16'd0 || quad_high_i[31:0] != 32'd0 || low_nz) begin
          mid_o.bits = {sign, 31'd0} | q2s_pkg::QNan | {10'd0, quad_high_i[46:25]};
          if (!xm[15]) begin
            trp        = (te_i & q2s_pkg::ExcNv) != 5'd0;
            mid_o.exc  = q2s_pkg::ExcNv;
            mid_o.wr   = !trp;
          end
        end else begin
          mid_o.bits = {sign, 31'd0} | q2s_pkg::Inf;
        end
      end else begin
        mid_o.bits = {sign, 31'd0} |
          ((rm == q2s_pkg::RmNearest || rm == q2s_pkg::RmUp) ? q2s_pkg::Inf
                                                              : q2s_pkg::MaxFin);
        trp       = (te_i & (q2s_pkg::ExcOf | q2s_pkg::ExcNx)) != 5'd0;
        mid_o.exc = q2s_pkg::ExcOf | q2s_pkg::ExcNx;
        mid_o.wr  = !trp;
      end
    end else if (xm < q2s_pkg::XmTiny) begin
      if (quad_high_i[62:0] == 63'd0 && !low_nz) begin
        mid_o.bits = {sign, 31'd0};
      end else begin
        mid_o.bits = {sign, 30'd0, rm == q2s_pkg::RmUp};
        trp        = (te_i & (q2s_pkg::ExcUf | q2s_pkg::ExcNx)) != 5'd0;
        mid_o.exc  = q2s_pkg::ExcUf | q2s_pkg::ExcNx;
        mid_o.wr   = !trp;
      end
    end else if (xm < q2s_pkg::XmNorm) begin
      mid_o.kind   = q2s_pkg::KindSub;
      mid_o.bits   = {8'd0, 1'b0, wide[47:25]};
      mid_o.rnd    = wide[24];
      mid_o.sticky = (wide[23:0] != 24'd0) || (quad_high_i[24:0] != 25'd0) || low_nz;
    end else begin
      mid_o.kind   = q2s_pkg::KindNormal;
      mid_o.bits   = {1'b0, 31'((xm - q2s_pkg::XmBias) << 7) | {8'd0, frac23}};
      mid_o.rnd    = quad_high_i[24];
      mid_o.sticky = (quad_high_i[23:0] != 24'd0) || low_nz;
    end
    if (mid_o.kind == q2s_pkg::KindSpecial) begin
      mid_o.rnd = trp;
    end
  end

endmodule

@@ hdl/q2s_round.sv @@
module q2s_round (
  input  q2s_pkg::q2s_mid_t mid_i,
  output q2s_pkg::q2s_res_t res_o
);

  logic        sub;
  logic        inc;
  logic [31:0] u;
  logic [4:0]  exc;

  always_comb begin
    sub = (mid_i.kind == q2s_pkg::KindSub);
    u   = mid_i.bits;
    exc = 5'd0;
    inc = 1'b0;
    if (mid_i.rnd || mid_i.sticky) begin
      exc = q2s_pkg::ExcNx | (sub ? q2s_pkg::ExcUf : 5'd0);
      inc = (mid_i.rm == q2s_pkg::RmUp) ||
            (mid_i.rm == q2s_pkg::RmNearest && mid_i.rnd &&
             (mid_i.sticky || u[0]));
      if (inc) begin
        u = u + 32'd1;
        if (u >= q2s_pkg::Inf) begin
          exc = exc | q2s_pkg::ExcOf;
        end
      end
    end else if (sub && (mid_i.te & q2s_pkg::ExcUf) != 5'd0) begin
      exc = q2s_pkg::ExcUf;
    end
    if (mid_i.kind == q2s_pkg::KindSpecial) begin
      res_o.bits = mid_i.bits;
      res_o.exc  = mid_i.exc;
      res_o.wr   = mid_i.wr;
      res_o.trap = mid_i.rnd;
    end else begin
      res_o.bits = u | {mid_i.sign, 31'd0};
      res_o.exc  = exc;
      res_o.wr   = 1'b1;
      res_o.trap = (exc & mid_i.te) != 5'd0;
    end
  end

endmodule

@@ hdl/quad_to_single_float_convert.sv @@
// Channel | Direction | Signals
// input   | in        | in_valid_i, in_ready_o, quad_high_i, quad_low_i
// result  | out       | out_valid_o, out_ready_i, single_bits_o, exc_flags_o, ...
// config  | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// Three register stages: input, classify and align, round. One beat is taken
// every cycle unless the output stalls; a stage advances when the stage after
// it is empty or advancing. Reset clears the valid bits, rounding mode and trap
// enables. A stall holds full stages up to the first empty one; no beat is lost.
module quad_to_single_float_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] quad_high_i,
  input  logic [63:0] quad_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] single_bits_o,
  output logic [4:0]  exc_flags_o,
  output logic        flags_written_o,
  output logic        trap_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  logic [1:0]  rm_q;
  logic [4:0]  te_q;
  logic        v1_q, v2_q, v3_q;
  logic        adv1, adv2, adv3;
  logic [63:0] hi_q, lo_q;
  logic [1:0]  rm1_q;
  logic [4:0]  te1_q;
  q2s_pkg::q2s_mid_t mid_d, mid_q;
  q2s_pkg::q2s_res_t res_d, res_q;

  assign cfg_ready_o = 1'b1;
  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_q <= q2s_pkg::RmNearest;
      te_q <= 5'd0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          q2s_pkg::CfgRounding: rm_q <= cfg_data_i[1:0];
          q2s_pkg::CfgTrap:     te_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      hi_q  <= quad_high_i;
      lo_q  <= quad_low_i;
      rm1_q <= rm_q;
      te1_q <= te_q;
    end
    if (adv2 && v1_q) mid_q <= mid_d;
    if (adv3 && v2_q) res_q <= res_d;
  end

  q2s_classify u_classify (
    .quad_high_i(hi_q),
    .quad_low_i (lo_q),
    .rm_i       (rm1_q),
    .te_i       (te1_q),
    .mid_o      (mid_d)
  );

  q2s_round u_round (
    .mid_i(mid_q),
    .res_o(res_d)
  );

  assign out_valid_o     = v3_q;
  assign single_bits_o   = res_q.bits;
  assign exc_flags_o     = res_q.exc;
  assign flags_written_o = res_q.wr;
  assign trap_o          = res_q.trap;

endmodule

@@ hdl/q2s_checker.sv @@
module q2s_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  exc_flags_i,
  input logic        flags_written_i,
  input logic        trap_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result beat dropped");

  a_no_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !exc_flags_i[1]) else $error("divide flag raised");

  a_trap_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && trap_i |-> exc_flags_i != 5'd0) else $error("trap without flag");

  a_clean_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && exc_flags_i != 5'd0 |-> flags_written_i || trap_i)
    else $error("flags neither written nor trapped");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input blocked with output empty");

endmodule

bind quad_to_single_float_convert q2s_checker u_q2s_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .exc_flags_i    (exc_flags_o),
  .flags_written_i(flags_written_o),
  .trap_i         (trap_o)
);
